### rtl/core/chm_pkg.sv
// Package for the chained hash map engine: action codes, result struct,
// sentinel constant. No dependencies.
package chm_pkg;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_SPARE  = 2'd3
    } action_t;

    localparam logic [31:0] ABSENT_VALUE = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               found;
        logic               pool_full;
        logic [8:0]         entry_count;
        logic [31:0]        op_count;
    } result_t;

endpackage

### rtl/core/chm_if.sv
// Valid/ready channel interfaces for request and result items.
// No dependencies.
interface chm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
    modport source (output valid, action, key, new_value, input ready);
    modport sink   (input valid, action, key, new_value, output ready);
endinterface

interface chm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               found;
    logic               pool_full;
    logic [8:0]         entry_count;
    logic [31:0]        op_count;
    modport source (output valid, result_value, found, pool_full, entry_count, op_count,
                    input ready);
    modport sink   (input valid, result_value, found, pool_full, entry_count, op_count,
                    output ready);
endinterface

### rtl/core/chm_modulo.sv
// Iterative restoring modulo: 32-bit key by a 7-bit divisor, one bit a cycle.
// Depends on chm_pkg.
module chm_modulo
    import chm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [6:0]  remainder
);
    logic [31:0] shift_reg, shift_next;
    logic [6:0]  rem_reg, rem_next;
    logic [6:0]  div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [7:0]  trial;

    assign trial = {rem_reg, shift_reg[31]};

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done       = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = 6'd32;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = 7'(trial - {1'b0, div_reg});
            else
                rem_next = trial[6:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign remainder = rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end
endmodule

### rtl/core/chained_hash_map_engine_unit.sv
// Chained hash map engine: top level with sequencer and memories.
// Depends on chm_pkg, chm_if, chm_modulo.
//
// Use: requests enter on req (action, key, new_value); one result item per
// request leaves on rsp. bucket_count is written through cfg_we/cfg_data;
// the user must do so only while idle, as the block does not enforce it.
// 0 acts as 1, values above NUM_BUCKETS as NUM_BUCKETS. One request at a
// time: the key modulo (one bit a cycle in the divider), the bucket head
// read, then per chain entry visited an entry memory read and a compare,
// for a new key a pop of a free entry and the link-in, then counting the
// request and loading the output register. The next item can be taken in
// the cycle after the result is loaded.
// The result sits in an output register; the next request is taken while
// it waits, but its result is held until the receiver takes the last one.
// Reset: the head clearing pass and the free stack fill run together, one
// entry a cycle; no request is accepted during them. Counters and the
// divisor reset at once. A stalled receiver holds the result and stalls the
// engine once the next request's result is ready.
module chained_hash_map_engine_unit
    import chm_pkg::*;
#(
    parameter int NUM_BUCKETS = 64,
    parameter int NUM_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    chm_req_if.sink    req,
    chm_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data
);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int EW = $clog2(NUM_ENTRIES + 1);
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [EW-1:0] NIL = EW'(NUM_ENTRIES);

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_MOD    = 10'b0000000100,
        S_HEAD   = 10'b0000001000,
        S_ENTRY  = 10'b0000010000,
        S_CMP    = 10'b0000100000,
        S_POP    = 10'b0001000000,
        S_INSERT = 10'b0010000000,
        S_FINISH = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [EW-1:0] head_mem [NUM_BUCKETS];
    logic [31:0]   key_mem  [NUM_ENTRIES];
    logic [31:0]   val_mem  [NUM_ENTRIES];
    logic [EW-1:0] link_mem [NUM_ENTRIES];
    logic [IW-1:0] free_mem [NUM_ENTRIES];

    logic [EW-1:0] head_rd;
    logic [31:0]   key_rd, val_rd;
    logic [EW-1:0] link_rd;
    logic [IW-1:0] free_rd;

    logic [6:0]    bcnt_reg;
    logic [EW-1:0] free_top_reg, free_top_next;
    logic [8:0]    live_reg, live_next;
    logic [31:0]   ops_reg, ops_next;
    logic [EW-1:0] init_reg, init_next;

    logic [1:0]    act_reg, act_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   nval_reg, nval_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [EW-1:0] prev_reg, prev_next;
    logic [EW-1:0] steps_reg, steps_next;
    logic [31:0]   fval_reg, fval_next;
    logic          found_reg, found_next;
    logic          full_reg, full_next;

    result_t       out_reg, out_next;
    logic          ovalid_reg, ovalid_next;

    // memory ports
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [EW-1:0] head_wd;
    logic [BW-1:0] head_ra;
    logic          ent_we, val_we, link_we;
    logic [IW-1:0] ent_wa, val_wa, link_wa;
    logic [31:0]   val_wd;
    logic [EW-1:0] link_wd;
    logic [IW-1:0] ent_ra;
    logic          free_we;
    logic [IW-1:0] free_wa, free_ra;
    logic [IW-1:0] free_wd;

    logic [6:0]    div_eff;
    logic          mod_start, mod_done;
    logic [6:0]    mod_rem;

    always_comb
    begin
        if (bcnt_reg == 7'd0)
            div_eff = 7'd1;
        else if (32'(bcnt_reg) > NUM_BUCKETS)
            div_eff = 7'(NUM_BUCKETS);
        else
            div_eff = bcnt_reg;
    end

    chm_modulo u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.key),
        .divisor   (div_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    logic accept;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign mod_start = accept;

    assign rsp.valid        = ovalid_reg;
    assign rsp.result_value = out_reg.result_value;
    assign rsp.found        = out_reg.found;
    assign rsp.pool_full    = out_reg.pool_full;
    assign rsp.entry_count  = out_reg.entry_count;
    assign rsp.op_count     = out_reg.op_count;

    always_comb
    begin
        state_next    = state_reg;
        free_top_next = free_top_reg;
        live_next     = live_reg;
        ops_next      = ops_reg;
        init_next     = init_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        nval_next     = nval_reg;
        bkt_next      = bkt_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        fval_next     = fval_reg;
        found_next    = found_reg;
        full_next     = full_reg;
        out_next      = out_reg;
        ovalid_next   = ovalid_reg;
        head_we = 1'b0; head_wa = bkt_reg; head_wd = NIL; head_ra = bkt_reg;
        ent_we  = 1'b0; ent_wa = free_rd;
        val_we  = 1'b0; val_wa = cur_reg[IW-1:0]; val_wd = nval_reg;
        link_we = 1'b0; link_wa = prev_reg[IW-1:0]; link_wd = link_rd;
        ent_ra  = cur_reg[IW-1:0];
        free_we = 1'b0; free_wa = free_top_reg[IW-1:0]; free_wd = cur_reg[IW-1:0];
        free_ra = IW'(free_top_reg - EW'(1));

        if (ovalid_reg && rsp.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // clear heads and fill free stack, one entry a cycle each
                if (32'(init_reg) < NUM_BUCKETS)
                begin
                    head_we = 1'b1;
                    head_wa = BW'(init_reg);
                end
                if (32'(init_reg) < NUM_ENTRIES)
                begin
                    free_we = 1'b1;
                    free_wa = init_reg[IW-1:0];
                    free_wd = IW'(NUM_ENTRIES - 1 - 32'(init_reg));
                end
                init_next = init_reg + EW'(1);
                if (32'(init_reg) >= NUM_BUCKETS - 1 && 32'(init_reg) >= NUM_ENTRIES - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = req.action;
                    key_next   = req.key;
                    nval_next  = req.new_value;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    bkt_next   = BW'(mod_rem);
                    head_ra    = BW'(mod_rem);
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cur_next   = head_rd;
                prev_next  = NIL;
                steps_next = '0;
                found_next = 1'b0;
                full_next  = 1'b0;
                fval_next  = ABSENT_VALUE;
                ent_ra     = head_rd[IW-1:0];
                if (head_rd < NIL)
                    state_next = S_ENTRY;
                else if (act_reg == ACT_INSERT)
                    state_next = S_POP;
                else
                    state_next = S_FINISH;
            end
            S_ENTRY:
            begin
                // entry memory read in flight
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_rd == key_reg)
                begin
                    found_next = 1'b1;
                    fval_next  = val_rd;
                    if (act_reg == ACT_INSERT)
                    begin
                        val_we = 1'b1;
                    end
                    else if (act_reg == ACT_DELETE)
                    begin
                        if (prev_reg < NIL)
                            link_we = 1'b1;
                        else
                        begin
                            head_we = 1'b1;
                            head_wd = link_rd;
                        end
                        if (free_top_reg < NIL)
                        begin
                            free_we       = 1'b1;
                            free_top_next = free_top_reg + EW'(1);
                        end
                        if (live_reg != 9'd0)
                            live_next = live_reg - 9'd1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    steps_next = steps_reg + EW'(1);
                    ent_ra     = link_rd[IW-1:0];
                    if (link_rd < NIL && (steps_reg + EW'(1)) < NIL)
                        state_next = S_ENTRY;
                    else if (act_reg == ACT_INSERT)
                        state_next = S_POP;
                    else
                        state_next = S_FINISH;
                end
            end
            S_POP:
            begin
                // free_ra already points at top-1; head_ra re-read for the link
                if (free_top_reg != '0)
                begin
                    free_top_next = free_top_reg - EW'(1);
                    state_next    = S_INSERT;
                end
                else
                begin
                    full_next  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_INSERT:
            begin
                free_ra = free_top_reg[IW-1:0];
                ent_we  = 1'b1;
                ent_wa  = free_rd;
                val_we  = 1'b1;
                val_wa  = free_rd;
                link_we = 1'b1;
                link_wa = free_rd;
                link_wd = head_rd;
                head_we = 1'b1;
                head_wd = EW'(free_rd);
                live_next  = live_reg + 9'd1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                ops_next   = ops_reg + 32'd1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    out_next.result_value = fval_reg;
                    out_next.found        = found_reg;
                    out_next.pool_full    = full_reg;
                    out_next.entry_count  = live_reg;
                    out_next.op_count     = ops_reg;
                    ovalid_next           = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[head_ra];
        if (ent_we)
            key_mem[ent_wa] <= key_reg;
        if (val_we)
            val_mem[val_wa] <= val_wd;
        if (link_we)
            link_mem[link_wa] <= link_wd;
        key_rd  <= key_mem[ent_ra];
        val_rd  <= val_mem[ent_ra];
        link_rd <= link_mem[ent_ra];
        if (free_we)
            free_mem[free_wa] <= free_wd;
        free_rd <= free_mem[free_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            bcnt_reg     <= 7'd64;
            free_top_reg <= NIL;
            live_reg     <= '0;
            ops_reg      <= '0;
            init_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
                bcnt_reg <= cfg_data;
            free_top_reg <= free_top_next;
            live_reg     <= live_next;
            ops_reg      <= ops_next;
            init_reg     <= init_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        nval_reg  <= nval_next;
        bkt_reg   <= bkt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        fval_reg  <= fval_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        out_reg   <= out_next;
    end
endmodule

### rtl/core/chm_checker.sv
// Port-level checks for the chained hash map engine, bound to the top level.
// Depends on chm_pkg.
module chm_checker
    import chm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_found,
    input logic        rsp_pool_full,
    input logic [31:0] rsp_result_value,
    input logic [31:0] rsp_op_count
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_op_count))
        else $error("result dropped while stalled");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_found && rsp_pool_full))
        else $error("found and pool_full together");

    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_pool_full |-> rsp_result_value == ABSENT_VALUE)
        else $error("pool_full without sentinel");

    a_ops_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready ##1 rsp_valid && $changed(rsp_op_count)
        |-> rsp_op_count == $past(rsp_op_count) + 32'd1)
        else $error("op_count skipped");
endmodule

bind chained_hash_map_engine_unit chm_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_found        (rsp.found),
    .rsp_pool_full    (rsp.pool_full),
    .rsp_result_value (rsp.result_value),
    .rsp_op_count     (rsp.op_count)
);

### test/chm_result_checker.sv
// Result checker for the chained hash map engine: watches the request, result
// and register channels, keeps its own copy of the table and compares each item.
// Depends on chm_pkg and chm_if.
module chm_result_checker
    import chm_pkg::*;
#(
    parameter int NUM_BUCKETS = 64,
    parameter int NUM_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    chm_req_if         req,
    chm_rsp_if         rsp,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data,
    output int         failures
);

    localparam logic [8:0] NULL_LINK = 9'(NUM_ENTRIES);

    logic [8:0]  bucket_head [NUM_BUCKETS];
    logic [31:0] slot_key    [NUM_ENTRIES];
    logic [31:0] slot_value  [NUM_ENTRIES];
    logic [8:0]  slot_link   [NUM_ENTRIES];
    logic [8:0]  free_slots  [NUM_ENTRIES];
    int unsigned free_depth;
    logic [8:0]  live_count;
    logic [31:0] request_total;
    logic [6:0]  bucket_setting;
    result_t     expected_results[$];

    function automatic int unsigned bucket_divisor();
        int unsigned d;
        d = bucket_setting;
        if (d == 0)
            d = 1;
        if (d > NUM_BUCKETS)
            d = NUM_BUCKETS;
        return d;
    endfunction

    // Applies one request to the shadow table and returns what the block should answer.
    function automatic result_t apply_request(action_t act, logic [31:0] key, logic [31:0] val);
        result_t     r;
        int unsigned b;
        logic [8:0]  cur;
        logic [8:0]  prev;
        int unsigned steps;
        logic [8:0]  slot;
        b = key % bucket_divisor();
        cur = bucket_head[b];
        prev = NULL_LINK;
        steps = 0;
        r = '0;
        r.result_value = ABSENT_VALUE;
        while (cur < NULL_LINK && steps < NUM_ENTRIES && !r.found)
        begin
            if (slot_key[cur] == key)
                r.found = 1'b1;
            else
            begin
                prev = cur;
                cur = slot_link[cur];
                steps++;
            end
        end
        if (r.found)
        begin
            r.result_value = slot_value[cur];
            if (act == ACT_INSERT)
                slot_value[cur] = val;
            else if (act == ACT_DELETE)
            begin
                if (prev < NULL_LINK)
                    slot_link[prev] = slot_link[cur];
                else
                    bucket_head[b] = slot_link[cur];
                if (free_depth < NUM_ENTRIES)
                begin
                    free_slots[free_depth] = cur;
                    free_depth++;
                end
                if (live_count > 0)
                    live_count--;
            end
        end
        else if (act == ACT_INSERT)
        begin
            if (free_depth > 0)
            begin
                free_depth--;
                slot = free_slots[free_depth];
                slot_key[slot] = key;
                slot_value[slot] = val;
                slot_link[slot] = bucket_head[b];
                bucket_head[b] = slot;
                live_count++;
            end
            else
                r.pool_full = 1'b1;
        end
        request_total++;
        r.entry_count = live_count;
        r.op_count = request_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
                bucket_head[i] = NULL_LINK;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_link[i] = NULL_LINK;
                free_slots[i] = 9'(NUM_ENTRIES - 1 - i);
            end
            free_depth = NUM_ENTRIES;
            live_count = '0;
            request_total = '0;
            bucket_setting = 7'd64;
            expected_results.delete();
            failures = 0;
        end
        else
        begin
            if (cfg_we)
                bucket_setting = cfg_data;
            if (req.valid && req.ready)
                expected_results.push_back(apply_request(action_t'(req.action), req.key,
                                                         req.new_value));
            if (rsp.valid && rsp.ready)
            begin
                got.result_value = rsp.result_value;
                got.found = rsp.found;
                got.pool_full = rsp.pool_full;
                got.entry_count = rsp.entry_count;
                got.op_count = rsp.op_count;
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result item: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

endmodule

### test/chained_hash_map_engine_unit_tb.sv
// Testbench top for the chained hash map engine: clock, reset, request and
// register stimulus, receiver stalls and the verdict.
// Depends on chm_pkg, chm_if, the engine RTL and chm_result_checker.
module chained_hash_map_engine_unit_tb;
    import chm_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_data;
    logic        stalls_on;
    int          failures;
    int          requests_sent;
    int          results_seen;
    int          cycle_count;
    logic [31:0] key_pool[48];

    chm_req_if req_ch();
    chm_rsp_if rsp_ch();

    chained_hash_map_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    chm_result_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .failures (failures)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready <= !(stalls_on && $urandom_range(99) < 6);
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            results_seen <= results_seen + 1;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(action_t act, logic [31:0] key, logic [31:0] val);
        @(negedge clk);
        while (stalls_on && $urandom_range(99) < 6)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.key <= key;
        req_ch.new_value <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
    endtask

    // Drains outstanding results, then writes the bucket count while idle.
    task automatic set_buckets(logic [6:0] n);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (results_seen != requests_sent)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= n;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        action_t     act;
        logic [31:0] key;
        int          pick;
        for (int i = 0; i < 48; i++)
            key_pool[i] = (i < 8) ? 32'(i * 64 + $urandom_range(3)) : $urandom;
        key_pool[8] = 32'h8000_0000;
        key_pool[9] = 32'h7FFF_FFFF;
        key_pool[10] = 32'hFFFF_FFFF;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            act = pick < 45 ? ACT_INSERT : pick < 70 ? ACT_LOOKUP :
                  pick < 95 ? ACT_DELETE : ACT_SPARE;
            key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(47)] : $urandom;
            send_request(act, key, $urandom);
        end
    endtask

    initial
    begin
        logic [31:0] fill_base;
        logic [6:0]  settings[8];
        settings = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd65, 7'd33, 7'd2, 7'd64};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        stalls_on = 1'b1;
        requests_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_LOOKUP;
        req_ch.key = '0;
        req_ch.new_value = '0;
        rsp_ch.ready = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extreme keys and values, chain collisions
        send_request(ACT_LOOKUP, 32'd0, 32'd0);
        send_request(ACT_DELETE, 32'd5, 32'd0);
        send_request(ACT_INSERT, 32'h8000_0000, 32'h8000_0000);
        send_request(ACT_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'd64, 32'd5);
        send_request(ACT_INSERT, 32'd128, 32'h1234_5678);
        send_request(ACT_LOOKUP, 32'd0, 32'd0);
        send_request(ACT_LOOKUP, 32'd64, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'd0, 32'd7);
        send_request(ACT_SPARE, 32'd0, 32'd99);
        send_request(ACT_SPARE, 32'd1, 32'd99);
        send_request(ACT_DELETE, 32'd64, 32'd0);
        send_request(ACT_DELETE, 32'd64, 32'd0);
        send_request(ACT_LOOKUP, 32'd0, 32'd0);
        send_request(ACT_LOOKUP, 32'h8000_0000, 32'd0);
        send_request(ACT_DELETE, 32'd128, 32'd0);
        send_request(ACT_DELETE, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_LOOKUP, 32'h7FFF_FFFF, 32'd0);

        // fill the pool past its end, then empty it again, with no stalls
        stalls_on = 1'b0;
        fill_base = $urandom;
        for (int i = 0; i < 262; i++)
            send_request(ACT_INSERT, fill_base + 32'(i), $urandom);
        send_request(ACT_LOOKUP, fill_base, 32'd0);
        for (int i = 0; i < 262; i++)
            send_request(ACT_DELETE, fill_base + 32'(i), 32'd0);
        stalls_on = 1'b1;

        random_phase(235);
        foreach (settings[i])
        begin
            set_buckets(settings[i]);
            random_phase(i == 0 ? 40 : 90);
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (results_seen != requests_sent)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
